### src/rrcpa_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and constants for the reserved-region carving page allocator.
// No dependencies; imported by every module of the block.
package rrcpa_pkg;

	typedef struct packed {
		logic [63:0] lo;
		logic [63:0] hi;
	} span_t;

	localparam int MAX_RESERVED_DEF = 128;
	localparam logic [63:0] PAGE_BYTES = 64'd4096;
	localparam logic [63:0] PAGE_MASK = PAGE_BYTES - 64'd1;

	localparam int MIN_W = 41;
	localparam logic [MIN_W-1:0] MIN_REGION_RESET = 41'd4194304;

	localparam int CFG_ADDR_W = 4;
	localparam logic REG_MIN_REGION = 1'b0;

	localparam logic [1:0] OP_RESERVE = 2'd0;
	localparam logic [1:0] OP_OFFER = 2'd1;
	localparam logic [1:0] OP_ALLOC = 2'd2;
	localparam logic [1:0] OP_CLEAR = 2'd3;

	localparam logic [2:0] STAT_OK = 3'd0;
	localparam logic [2:0] STAT_FULL = 3'd1;
	localparam logic [2:0] STAT_REJECT = 3'd2;
	localparam logic [2:0] STAT_NO_PAGE = 3'd3;
	localparam logic [2:0] STAT_IGNORED = 3'd4;

endpackage

### src/rrcpa_table.sv
`timescale 1ns / 1ps
// Reserved range table: one write port, one registered read port.
// Depends on rrcpa_pkg for span_t.
module rrcpa_table import rrcpa_pkg::*; #(
	parameter int DEPTH = MAX_RESERVED_DEF,
	parameter int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [IDX_W-1:0] wr_addr,
	input  span_t            wr_data,
	input  logic [IDX_W-1:0] rd_addr,
	output span_t            rd_data
);

	span_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule

### src/rrcpa_carve.sv
`timescale 1ns / 1ps
// Interval subtraction unit: removes one reserved span from the current span.
// Depends on rrcpa_pkg for span_t; shared across all table entries.
module rrcpa_carve import rrcpa_pkg::*; (
	input  span_t cur,
	input  span_t rsv,
	output span_t res
);

	logic [63:0] lower_len;
	logic [63:0] upper_len;

	assign lower_len = rsv.lo - cur.lo;
	assign upper_len = cur.hi - rsv.hi;

	always_comb begin
		if (cur.hi <= cur.lo || rsv.hi <= rsv.lo) begin
			res = '0;
		end else if (cur.lo == rsv.lo && cur.hi == rsv.hi) begin
			res = '0;
		end else if (rsv.hi <= cur.lo || rsv.lo >= cur.hi) begin
			res = cur;
		end else if (rsv.lo <= cur.lo) begin
			res.lo = rsv.hi;
			res.hi = cur.hi;
		end else if (rsv.hi >= cur.hi) begin
			res.lo = cur.lo;
			res.hi = rsv.lo;
		end else if (lower_len > upper_len) begin
			res.lo = cur.lo;
			res.hi = rsv.lo;
		end else begin
			res.lo = rsv.hi;
			res.hi = cur.hi;
		end
	end

endmodule

### src/reserved_region_carving_page_allocator.sv
`timescale 1ns / 1ps
// Top level: sequencer, allocator window, config register and result register.
// Depends on rrcpa_pkg, rrcpa_table and rrcpa_carve.
//
//  channel | signals                                        | direction
//  --------+------------------------------------------------+----------
//  in      | in_valid/in_ready, opcode, region_base/limit   | sink
//  out     | out_valid/out_ready, status, page_address,     | source
//          | window_base, window_top                        |
//  cfg     | psel, penable, pwrite, paddr, pwdata, prdata   | APB slave
//
// Reserve, allocate, clear, rejected or ignored offer: result valid the cycle after accept.
// A carving offer: S_CARVE takes one table entry per cycle through the single carve
// unit fed by the table's registered read port, then S_FINAL registers the result.
// Reset empties the table through its count alone; no clearing pass is needed.
// A new beat is taken only when idle and the result register is free or draining.
module reserved_region_carving_page_allocator import rrcpa_pkg::*; #(
	parameter int MAX_RESERVED = MAX_RESERVED_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [1:0]            opcode,
	input  logic [63:0]           region_base,
	input  logic [63:0]           region_limit,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [2:0]            status,
	output logic [63:0]           page_address,
	output logic [63:0]           window_base,
	output logic [63:0]           window_top,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [63:0]           pwdata,
	output logic [63:0]           prdata,
	output logic                  pready
);

	localparam int IDX_W = (MAX_RESERVED > 1) ? $clog2(MAX_RESERVED) : 1;
	localparam int CNT_W = $clog2(MAX_RESERVED + 1);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_CARVE = 2'd1;
	localparam logic [1:0] S_FINAL = 2'd2;

	logic [1:0]       state_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] idx_q;
	logic [CNT_W-1:0] idx_nx;
	logic [63:0]      alloc_next_q;
	logic [63:0]      alloc_top_q;
	logic [MIN_W-1:0] min_q;
	logic             out_valid_q;
	span_t            r_q;
	logic [2:0]       status_q;
	logic [63:0]      page_q;
	logic [63:0]      wbase_q;
	logic [63:0]      wtop_q;

	logic        accept;
	logic        cfg_wr;
	span_t       req;
	span_t       rd_data;
	span_t       carve_res;
	logic [63:0] req_len;
	logic [63:0] r_len;
	logic [63:0] min_ext;
	logic        win_present;
	logic        alloc_fail;
	logic        fin_ok;
	logic [64:0] nb_sum;
	logic [63:0] top_al;
	logic [63:0] nb;

	logic        load;
	logic [2:0]  ld_status;
	logic [63:0] ld_page;
	logic [63:0] nxt_next;
	logic [63:0] nxt_top;
	logic        cnt_inc;
	logic        cnt_clr;
	logic        start_carve;
	logic        tbl_wr;

	assign in_ready = (state_q == S_IDLE) && (!out_valid_q || out_ready);
	assign accept = in_valid && in_ready;
	assign req.lo = region_base;
	assign req.hi = region_limit;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[3] == REG_MIN_REGION);
	assign prdata = (paddr[3] == REG_MIN_REGION) ? {{(64-MIN_W){1'b0}}, min_q} : 64'd0;

	assign idx_nx = idx_q + CNT_W'(1);

	rrcpa_table #(
		.DEPTH(MAX_RESERVED),
		.IDX_W(IDX_W)
	) u_table (
		.clk    (clk),
		.wr_en  (tbl_wr),
		.wr_addr(cnt_q[IDX_W-1:0]),
		.wr_data(req),
		.rd_addr((state_q == S_CARVE) ? idx_nx[IDX_W-1:0] : {IDX_W{1'b0}}),
		.rd_data(rd_data)
	);

	rrcpa_carve u_carve (
		.cur(r_q),
		.rsv(rd_data),
		.res(carve_res)
	);

	assign req_len = (region_limit > region_base) ? (region_limit - region_base) : 64'd0;
	assign r_len = (r_q.hi > r_q.lo) ? (r_q.hi - r_q.lo) : 64'd0;
	assign min_ext = {{(64-MIN_W){1'b0}}, min_q};
	assign win_present = (alloc_next_q != 64'd0) || (alloc_top_q != 64'd0);
	assign alloc_fail = (alloc_next_q == 64'd0) || (alloc_top_q < PAGE_BYTES) ||
		(alloc_next_q > alloc_top_q - PAGE_BYTES);
	assign fin_ok = r_len > min_ext;
	assign nb_sum = {1'b0, r_q.lo} + {1'b0, PAGE_MASK};
	assign top_al = r_q.hi & ~PAGE_MASK;
	assign nb = nb_sum[64] ? top_al : (nb_sum[63:0] & ~PAGE_MASK);

	always_comb begin
		load = 1'b0;
		ld_status = STAT_OK;
		ld_page = 64'd0;
		nxt_next = alloc_next_q;
		nxt_top = alloc_top_q;
		cnt_inc = 1'b0;
		cnt_clr = 1'b0;
		start_carve = 1'b0;
		tbl_wr = 1'b0;
		if (state_q == S_IDLE && accept) begin
			case (opcode)
				OP_RESERVE: begin
					load = 1'b1;
					if (cnt_q >= CNT_W'(MAX_RESERVED)) begin
						ld_status = STAT_FULL;
					end else begin
						cnt_inc = 1'b1;
						tbl_wr = 1'b1;
					end
				end
				OP_OFFER: begin
					if (win_present) begin
						load = 1'b1;
						ld_status = STAT_IGNORED;
					end else if (req_len < min_ext) begin
						load = 1'b1;
						ld_status = STAT_REJECT;
					end else begin
						start_carve = 1'b1;
					end
				end
				OP_ALLOC: begin
					load = 1'b1;
					if (alloc_fail) begin
						ld_status = STAT_NO_PAGE;
					end else begin
						ld_page = alloc_next_q;
						nxt_next = alloc_next_q + PAGE_BYTES;
					end
				end
				default: begin
					load = 1'b1;
					cnt_clr = 1'b1;
					nxt_next = 64'd0;
					nxt_top = 64'd0;
				end
			endcase
		end else if (state_q == S_FINAL) begin
			load = 1'b1;
			if (fin_ok) begin
				nxt_next = nb;
				nxt_top = top_al;
			end else begin
				ld_status = STAT_REJECT;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			idx_q <= '0;
			alloc_next_q <= 64'd0;
			alloc_top_q <= 64'd0;
			min_q <= MIN_REGION_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr) begin
				min_q <= pwdata[MIN_W-1:0];
			end
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end
			alloc_next_q <= nxt_next;
			alloc_top_q <= nxt_top;
			if (cnt_clr) begin
				cnt_q <= '0;
			end else if (cnt_inc) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			case (state_q)
				S_IDLE: begin
					if (start_carve) begin
						idx_q <= '0;
						state_q <= (cnt_q == '0) ? S_FINAL : S_CARVE;
					end
				end
				S_CARVE: begin
					if (idx_nx == cnt_q) begin
						state_q <= S_FINAL;
					end else begin
						idx_q <= idx_nx;
					end
				end
				S_FINAL: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (start_carve) begin
			r_q <= req;
		end else if (state_q == S_CARVE) begin
			r_q <= carve_res;
		end
		if (load) begin
			status_q <= ld_status;
			page_q <= ld_page;
			wbase_q <= nxt_next;
			wtop_q <= nxt_top;
		end
	end

	assign out_valid = out_valid_q;
	assign status = status_q;
	assign page_address = page_q;
	assign window_base = wbase_q;
	assign window_top = wtop_q;

`ifndef SYNTH
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> (state_q == S_IDLE))
		else $error("input ready outside idle");
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_RESERVED))
		else $error("reserved count beyond table depth");
	a_carve_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CARVE) |-> (idx_q < cnt_q))
		else $error("carve index past reserved count");
	a_reserve_inc: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && opcode == OP_RESERVE && cnt_q < CNT_W'(MAX_RESERVED)) |=>
		(cnt_q == $past(cnt_q) + CNT_W'(1)))
		else $error("reserve beat did not advance count");
	a_window_align: assert property (@(posedge clk) disable iff (!arst_n)
		((alloc_next_q & PAGE_MASK) == 64'd0) && ((alloc_top_q & PAGE_MASK) == 64'd0))
		else $error("allocator window not page aligned");
`endif

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps
// Testbench for reserved_region_carving_page_allocator: directed table, then random phases.
// Depends on rrcpa_pkg and the block's RTL; predicts results with its own allocator model.
module tb_top;
	import rrcpa_pkg::*;

	localparam int MAX_RSV = MAX_RESERVED_DEF;
	localparam int PHASES = 8;
	localparam int PHASE_ITEMS = 250;
	localparam int WDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 140;
	localparam logic [63:0] MIN_MASK = (64'd1 << MIN_W) - 64'd1;
	localparam logic [CFG_ADDR_W-1:0] MIN_REGION_ADDR = CFG_ADDR_W'(REG_MIN_REGION) << 3;

	typedef struct packed {
		logic [2:0]  status;
		logic [63:0] page;
		logic [63:0] wbase;
		logic [63:0] wtop;
	} alloc_result_t;

	typedef struct {
		logic [1:0]    op;
		logic [63:0]   base;
		logic [63:0]   limit;
		bit            typed;
		alloc_result_t res;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] opcode = OP_CLEAR;
	logic [63:0] region_base = '0;
	logic [63:0] region_limit = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [2:0] status;
	logic [63:0] page_address;
	logic [63:0] window_base;
	logic [63:0] window_top;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [CFG_ADDR_W-1:0] paddr = '0;
	logic [63:0] pwdata = '0;
	logic [63:0] prdata;
	logic pready;

	bit beat_typed = 1'b0;
	alloc_result_t beat_res = '0;

	span_t rsv_tab [MAX_RSV];
	int unsigned rsv_cnt = 0;
	logic [63:0] win_next = '0;
	logic [63:0] win_top = '0;
	logic [63:0] min_bytes = 64'(MIN_REGION_RESET);

	alloc_result_t pending_results [$];
	stim_row_t dir_rows [$];
	int errors = 0;
	int items_sent = 0;
	int send_idle = 0;
	int recv_stall = 0;
	int quiet_cycles = 0;

	reserved_region_carving_page_allocator dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.opcode(opcode), .region_base(region_base), .region_limit(region_limit),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .page_address(page_address),
		.window_base(window_base), .window_top(window_top),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [63:0] span_bytes(span_t s);
		return (s.hi > s.lo) ? s.hi - s.lo : 64'd0;
	endfunction

	function automatic span_t carve_span(span_t a, span_t b);
		span_t z;
		span_t lower;
		span_t upper;
		z = '0;
		if (a.hi <= a.lo || b.hi <= b.lo) return z;
		if (a.lo == b.lo && a.hi == b.hi) return z;
		if (b.hi <= a.lo || b.lo >= a.hi) return a;
		lower.lo = a.lo;
		lower.hi = b.lo;
		upper.lo = b.hi;
		upper.hi = a.hi;
		if (b.lo <= a.lo) return upper;
		if (b.hi >= a.hi) return lower;
		if (lower.hi - lower.lo > upper.hi - upper.lo) return lower;
		return upper;
	endfunction

	function automatic alloc_result_t predict_alloc(logic [1:0] op, logic [63:0] b,
			logic [63:0] l);
		alloc_result_t r;
		span_t req;
		span_t rem;
		logic [63:0] nb;
		logic [63:0] top;
		r = '0;
		r.status = STAT_OK;
		req.lo = b;
		req.hi = l;
		case (op)
			OP_RESERVE: begin
				if (rsv_cnt >= MAX_RSV) begin
					r.status = STAT_FULL;
				end else begin
					rsv_tab[rsv_cnt] = req;
					rsv_cnt++;
				end
			end
			OP_OFFER: begin
				if (win_next != 0 || win_top != 0) begin
					r.status = STAT_IGNORED;
				end else if (span_bytes(req) < min_bytes) begin
					r.status = STAT_REJECT;
				end else begin
					rem = req;
					for (int i = 0; i < rsv_cnt; i++) rem = carve_span(rem, rsv_tab[i]);
					if (span_bytes(rem) > min_bytes) begin
						top = rem.hi & ~PAGE_MASK;
						nb = rem.lo + PAGE_MASK;
						if (nb < rem.lo) nb = top;
						else nb = nb & ~PAGE_MASK;
						win_next = nb;
						win_top = top;
					end else begin
						r.status = STAT_REJECT;
					end
				end
			end
			OP_ALLOC: begin
				if (win_next == 0 || win_top < PAGE_BYTES || win_next > win_top - PAGE_BYTES) begin
					r.status = STAT_NO_PAGE;
				end else begin
					r.page = win_next;
					win_next = win_next + PAGE_BYTES;
				end
			end
			default: begin
				rsv_cnt = 0;
				win_next = '0;
				win_top = '0;
			end
		endcase
		r.wbase = win_next;
		r.wtop = win_top;
		return r;
	endfunction

	always @(posedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= recv_stall);
	end

	always @(posedge clk) begin
		alloc_result_t exp_res;
		alloc_result_t pred;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (pending_results.size() == 0) begin
					$error("result beat with no expectation pending");
					errors++;
				end else begin
					exp_res = pending_results.pop_front();
					if (status !== exp_res.status) begin
						$error("status: expected %0d, got %0d", exp_res.status, status);
						errors++;
					end
					if (page_address !== exp_res.page) begin
						$error("page_address: expected %h, got %h", exp_res.page, page_address);
						errors++;
					end
					if (window_base !== exp_res.wbase) begin
						$error("window_base: expected %h, got %h", exp_res.wbase, window_base);
						errors++;
					end
					if (window_top !== exp_res.wtop) begin
						$error("window_top: expected %h, got %h", exp_res.wtop, window_top);
						errors++;
					end
				end
			end
			if (in_valid && in_ready) begin
				pred = predict_alloc(opcode, region_base, region_limit);
				pending_results.push_back(beat_typed ? beat_res : pred);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
			else quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WDOG_LIMIT) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	task automatic send(input logic [1:0] op, input logic [63:0] b, input logic [63:0] l,
			input bit typed, input alloc_result_t res);
		while ($urandom_range(0, 99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		region_base <= b;
		region_limit <= l;
		beat_typed <= typed;
		beat_res <= res;
		do @(posedge clk); while (!in_ready);
		items_sent++;
	endtask

	task automatic send_op(input logic [1:0] op, input logic [63:0] b, input logic [63:0] l);
		send(op, b, l, 1'b0, '0);
	endtask

	task automatic row(input logic [1:0] op, input logic [63:0] b, input logic [63:0] l,
			input bit typed, input logic [2:0] st);
		stim_row_t r;
		r.op = op;
		r.base = b;
		r.limit = l;
		r.typed = typed;
		r.res = '0;
		r.res.status = st;
		dir_rows.push_back(r);
	endtask

	task automatic write_min_region(input logic [63:0] v);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= MIN_REGION_ADDR;
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		min_bytes = v & MIN_MASK;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic random_sequence(input int kind);
		logic [63:0] lo;
		logic [63:0] hi;
		logic [63:0] len;
		logic [63:0] rlo;
		logic [63:0] rhi;
		int n;
		lo = rand64() >> $urandom_range(1, 63);
		len = (rand64() >> $urandom_range(12, 63)) + min_bytes + 64'($urandom_range(0, 1));
		hi = lo + len;
		case (kind)
			0, 1, 2, 3, 4, 5, 8: begin
				send_op(OP_CLEAR, rand64(), rand64());
				n = (kind == 8) ? MAX_RSV + $urandom_range(1, 3) : $urandom_range(0, 5);
				repeat (n) begin
					rlo = lo + rand64() % (len + 1);
					rhi = rlo + rand64() % (len / 2 + 1) + 1;
					case ($urandom_range(0, 19))
						0: begin rlo = lo; rhi = hi; end
						1: rhi = rlo - $urandom_range(0, 1);
						2: begin rlo = lo - (lo >> 4); rhi = hi + (len >> 2); end
						3, 4: begin rlo = rand64(); rhi = rlo + (rand64() >> $urandom_range(1, 63)); end
						default: ;
					endcase
					send_op(OP_RESERVE, rlo, rhi);
				end
				send_op(OP_OFFER, lo, hi);
				if ($urandom_range(0, 3) == 0) send_op(OP_OFFER, rand64(), rand64());
				repeat ($urandom_range(0, 8)) send_op(OP_ALLOC, rand64(), rand64());
			end
			6: begin
				repeat ($urandom_range(1, 4))
					send_op(2'($urandom_range(0, 3)), rand64(), rand64());
			end
			7: begin
				send_op(OP_CLEAR, '0, '0);
				hi = ~64'd0 - $urandom_range(0, 3);
				lo = hi - $urandom_range(0, 20000);
				send_op(OP_OFFER, lo, hi);
				repeat ($urandom_range(1, 3)) send_op(OP_ALLOC, '0, '0);
			end
			default: begin
				repeat ($urandom_range(1, 40)) send_op(OP_ALLOC, rand64(), rand64());
			end
		endcase
	endtask

	initial begin
		logic [63:0] cfg_vals [PHASES];
		int start;
		int kind;
		int seq_cnt;

		cfg_vals[0] = 64'(MIN_REGION_RESET);
		cfg_vals[1] = 64'd0;
		cfg_vals[2] = PAGE_BYTES;
		cfg_vals[3] = 64'd1 << 40;
		cfg_vals[4] = rand64() % ((64'd1 << 40) + 1);
		cfg_vals[5] = 64'(MIN_REGION_RESET);
		cfg_vals[6] = 64'd0;
		cfg_vals[7] = 64'($urandom_range(0, 65536));

		row(OP_ALLOC, 64'h0, 64'h0, 1'b1, STAT_NO_PAGE);
		row(OP_OFFER, 64'h1000, 64'h2000, 1'b1, STAT_REJECT);
		row(OP_OFFER, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 1'b1, STAT_REJECT);
		row(OP_RESERVE, 64'h8000_0000, 64'h9000_0000, 1'b1, STAT_OK);
		row(OP_RESERVE, 64'h1_0000_0000, 64'h2_0000_0000, 1'b1, STAT_OK);
		row(OP_RESERVE, 64'h4_0040_0000, 64'h4_0080_0000, 1'b1, STAT_OK);
		row(OP_RESERVE, 64'hFFFF_FFFF_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, STAT_OK);
		row(OP_OFFER, 64'h8000_0000, 64'h9000_0000, 1'b0, STAT_OK);
		row(OP_OFFER, 64'h1_4000_0000, 64'h1_8000_0000, 1'b0, STAT_OK);
		row(OP_OFFER, 64'h4_0000_0000, 64'h4_00C0_0000, 1'b0, STAT_OK);
		row(OP_OFFER, 64'h4_0000_0000, 64'h4_0100_0123, 1'b0, STAT_OK);
		row(OP_OFFER, 64'h10_0000_0000, 64'h20_0000_0000, 1'b0, STAT_OK);
		row(OP_ALLOC, 64'h0, 64'h0, 1'b0, STAT_OK);
		row(OP_ALLOC, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, STAT_OK);
		row(OP_RESERVE, 64'h7000, 64'h6000, 1'b0, STAT_OK);
		row(OP_RESERVE, 64'h0, 64'h0, 1'b0, STAT_OK);
		row(OP_CLEAR, 64'h0, 64'h0, 1'b1, STAT_OK);
		row(OP_RESERVE, 64'h2000, 64'h1000, 1'b0, STAT_OK);
		row(OP_OFFER, 64'h10_0000_0000, 64'h20_0000_0000, 1'b0, STAT_OK);
		row(OP_CLEAR, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, STAT_OK);
		row(OP_RESERVE, 64'h30_0100_0000, 64'h30_0110_0000, 1'b0, STAT_OK);
		row(OP_OFFER, 64'h30_0000_0001, 64'h30_0120_0000, 1'b0, STAT_OK);
		row(OP_ALLOC, 64'h0, 64'h0, 1'b0, STAT_OK);
		row(OP_CLEAR, 64'h0, 64'h0, 1'b1, STAT_OK);
		row(OP_OFFER, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, STAT_OK);
		row(OP_ALLOC, 64'h0, 64'h0, 1'b0, STAT_OK);
		row(OP_CLEAR, 64'h0, 64'h0, 1'b1, STAT_OK);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int p = 0; p < PHASES; p++) begin
			if (p > 0) begin
				in_valid <= 1'b0;
				write_min_region(cfg_vals[p]);
				@(posedge clk);
			end
			send_idle = (p % 4 == 1) ? 58 : (p % 4 == 3) ? 27 : 0;
			recv_stall = (p % 4 == 2) ? 58 : (p % 4 == 3) ? 27 : 0;
			if (p == 0) begin
				foreach (dir_rows[i])
					send(dir_rows[i].op, dir_rows[i].base, dir_rows[i].limit,
						dir_rows[i].typed, dir_rows[i].res);
			end
			start = items_sent;
			seq_cnt = 0;
			while (items_sent - start < PHASE_ITEMS) begin
				kind = $urandom_range(0, 9);
				if (kind == 8 && $urandom_range(0, 5) != 0) kind = 0;
				if (p == 2 && seq_cnt == 0) kind = 8;
				random_sequence(kind);
				seq_cnt++;
			end
		end
		in_valid <= 1'b0;

		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_results.size() != 0) begin
			$error("%0d expected results never arrived", pending_results.size());
			errors++;
		end
		if (errors == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
